// File: rtl/mips_itype_execute_top_defines.svh
// shared assertion macros for the execute block
`ifndef MIPS_ITYPE_EXECUTE_TOP_DEFINES_SVH
`define MIPS_ITYPE_EXECUTE_TOP_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define MIE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// condition that must never hold outside reset
`define MIE_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/mie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mie_pkg;

    localparam int MEM_BYTES_DEF = 1024;
    localparam int OQ_DEPTH      = 4;
    localparam int OQ_CW         = $clog2(OQ_DEPTH + 1);

    typedef enum logic [3:0] {
        CMD_BEQ  = 4'd0,
        CMD_BNE  = 4'd1,
        CMD_ADDI = 4'd2,
        CMD_ANDI = 4'd3,
        CMD_ORI  = 4'd4,
        CMD_NORI = 4'd5,
        CMD_LUI  = 4'd6,
        CMD_SLTI = 4'd7,
        CMD_LW   = 4'd8,
        CMD_LH   = 4'd9,
        CMD_LHU  = 4'd10,
        CMD_LB   = 4'd11,
        CMD_LBU  = 4'd12,
        CMD_SW   = 4'd13,
        CMD_SH   = 4'd14,
        CMD_SB   = 4'd15
    } mie_cmd_t;

    typedef struct packed {
        logic [3:0]  command;
        logic [4:0]  src_reg;
        logic [4:0]  dst_reg;
        logic [15:0] immediate;
    } mie_in_t;

    typedef struct packed {
        logic        write_zero_error;
        logic        number_overflow;
        logic        address_overflow;
        logic        misaligned;
        logic        halt;
        logic        branch_taken;
        logic        reg_written;
        logic        mem_written;
        logic [31:0] result_value;
        logic [31:0] next_pc;
    } mie_out_t;

    typedef struct packed {
        mie_cmd_t    cmd;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [15:0] imm;
        logic        is_branch;
        logic        is_alu;
        logic        is_load;
        logic        is_store;
        logic        wr_reg;
    } mie_dec_t;

endpackage
`default_nettype wire

// File: rtl/mips_itype_execute_top.sv
// path: an item passes the front queue, stage 2 and stage 3 and the result queue
// throughput: one instruction per cycle while the result queue has room; an instruction
//   that reads a register written by the one just before it is held while that write is in stage 2
// reset: async active low; registers and pc read zero, then the data memory
//   is swept to zero, word by word, before any issue
`timescale 1ns / 1ps
`default_nettype none
`include "mips_itype_execute_top_defines.svh"
module mips_itype_execute_top #(
    parameter int MEM_BYTES = mie_pkg::MEM_BYTES_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire mie_pkg::mie_in_t item,
    output logic                  full,
    input  wire logic             pop,
    output logic                  empty,
    output mie_pkg::mie_out_t     result
);

    mie_pkg::mie_dec_t          head;
    logic                       head_valid;
    logic                       issue;
    logic [mie_pkg::OQ_CW-1:0]  oq_count;
    mie_pkg::mie_out_t          res;
    logic                       res_valid;

    mie_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .item       (item),
        .full       (full),
        .issue      (issue),
        .head       (head),
        .head_valid (head_valid)
    );

    mie_back #(
        .MEM_BYTES (MEM_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .issue      (issue),
        .oq_count   (oq_count),
        .res        (res),
        .res_valid  (res_valid)
    );

    mie_outq u_outq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (res_valid),
        .wdata  (res),
        .pop    (pop),
        .empty  (empty),
        .result (result),
        .count  (oq_count)
    );

    `MIE_ASSERT_IMPL(a_halt_src, !empty && result.halt, result.address_overflow || result.misaligned, "halt without address error")
    `MIE_ASSERT_IMPL(a_no_write_on_err, !empty && (result.reg_written || result.mem_written), !result.write_zero_error && !result.number_overflow && !result.halt, "write despite error")
    `MIE_ASSERT_IMPL(a_pc_aligned, !empty, result.next_pc[1:0] == 2'b00, "pc not word aligned")
    `MIE_ASSERT_NEVER(a_oq_overflow, res_valid && (oq_count == mie_pkg::OQ_CW'(mie_pkg::OQ_DEPTH)) && !(pop && !empty), "result queue overrun")

endmodule
`default_nettype wire

// File: rtl/mie_front.sv
`timescale 1ns / 1ps
`default_nettype none
module mie_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire mie_pkg::mie_in_t item,
    output logic                  full,
    input  wire logic             issue,
    output mie_pkg::mie_dec_t     head,
    output logic                  head_valid
);

    mie_pkg::mie_dec_t q_reg [2];
    logic              wptr_reg, wptr_next;
    logic              rptr_reg, rptr_next;
    logic [1:0]        cnt_reg, cnt_next;
    mie_pkg::mie_dec_t dec;
    logic              do_push;

    always_comb
    begin
        dec.cmd       = mie_pkg::mie_cmd_t'(item.command);
        dec.rs        = item.src_reg;
        dec.rt        = item.dst_reg;
        dec.imm       = item.immediate;
        dec.is_branch = dec.cmd inside {mie_pkg::CMD_BEQ, mie_pkg::CMD_BNE};
        dec.is_alu    = dec.cmd inside {[mie_pkg::CMD_ADDI:mie_pkg::CMD_SLTI]};
        dec.is_load   = dec.cmd inside {[mie_pkg::CMD_LW:mie_pkg::CMD_LBU]};
        dec.is_store  = dec.cmd inside {[mie_pkg::CMD_SW:mie_pkg::CMD_SB]};
        dec.wr_reg    = dec.is_alu | dec.is_load;
    end

    assign full       = (cnt_reg == 2'd2);
    assign do_push    = push & ~full;
    assign head       = q_reg[rptr_reg];
    assign head_valid = (cnt_reg != 2'd0);

    always_comb
    begin
        wptr_next = wptr_reg ^ do_push;
        rptr_next = rptr_reg ^ issue;
        cnt_next  = cnt_reg + {1'b0, do_push} - {1'b0, issue};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wptr_reg] <= dec;
        end
    end

endmodule
`default_nettype wire

// File: rtl/mie_back.sv
`timescale 1ns / 1ps
`default_nettype none
module mie_back #(
    parameter int MEM_BYTES = mie_pkg::MEM_BYTES_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire mie_pkg::mie_dec_t       head,
    input  wire logic                    head_valid,
    output logic                         issue,
    input  wire logic [mie_pkg::OQ_CW-1:0] oq_count,
    output mie_pkg::mie_out_t            res,
    output logic                         res_valid
);

    localparam int MEM_WORDS = (MEM_BYTES + 3) / 4;
    localparam int AW        = $clog2(MEM_WORDS);

    logic [31:0]       rf_reg [32];
    logic [31:0]       mem [MEM_WORDS];
    logic              clearing_reg;
    logic [AW-1:0]     clr_idx_reg;

    // stage 2: operands read, alu / address / branch
    logic              b2_v_reg;
    mie_pkg::mie_dec_t b2_reg;
    logic [31:0]       b2_a_reg, b2_b_reg;
    logic [31:0]       pc_reg, pc_next;

    // stage 3: memory data back, merge and write
    logic              b3_v_reg;
    mie_pkg::mie_cmd_t b3_cmd_reg;
    logic [4:0]        b3_rt_reg;
    logic [1:0]        b3_lane_reg;
    logic [31:0]       b3_b_reg, b3_val_reg, b3_pc_reg, rdata_reg;
    logic [AW-1:0]     b3_idx_reg;
    logic              b3_ok_reg, b3_ld_reg, b3_st_reg, b3_alu_rw_reg;
    logic              b3_wz_reg, b3_nov_reg, b3_aov_reg, b3_mis_reg, b3_tk_reg;

    logic [31:0]       simm, zimm, sum, alu_val, addr;
    logic              add_ov, taken, wz, nov, aov, mis, ok, alu_rw;
    logic [AW-1:0]     idx;
    logic              hazard;
    logic [mie_pkg::OQ_CW-1:0] used;
    logic [31:0]       val3, word;
    logic              rw3, mw3;
    logic [31:0]       fwd_a, fwd_b;

    // issue stalls while an older register write that it may read is still in stage 2
    assign hazard = b2_v_reg && b2_reg.wr_reg && (b2_reg.rt != 5'd0)
                    && ((b2_reg.rt == head.rs) || (b2_reg.rt == head.rt));
    assign used   = oq_count + mie_pkg::OQ_CW'(b2_v_reg) + mie_pkg::OQ_CW'(b3_v_reg);
    assign issue  = head_valid && !clearing_reg && !hazard
                    && (used < mie_pkg::OQ_CW'(mie_pkg::OQ_DEPTH));

    assign fwd_a = (rw3 && b3_rt_reg == head.rs) ? val3 : rf_reg[head.rs];
    assign fwd_b = (rw3 && b3_rt_reg == head.rt) ? val3 : rf_reg[head.rt];

    always_comb
    begin
        simm   = {{16{b2_reg.imm[15]}}, b2_reg.imm};
        zimm   = {16'd0, b2_reg.imm};
        sum    = b2_a_reg + simm;
        add_ov = (~(b2_a_reg[31] ^ simm[31])) & (b2_a_reg[31] ^ sum[31]);
        addr   = sum;
        idx    = addr[AW+1:2];
        taken  = 1'b0;
        wz     = 1'b0;
        nov    = 1'b0;
        aov    = 1'b0;
        mis    = 1'b0;
        alu_val = 32'd0;
        case (b2_reg.cmd)
            mie_pkg::CMD_BEQ:  taken = (b2_a_reg == b2_b_reg);
            mie_pkg::CMD_BNE:  taken = (b2_a_reg != b2_b_reg);
            mie_pkg::CMD_ADDI: alu_val = sum;
            mie_pkg::CMD_ANDI: alu_val = b2_a_reg & zimm;
            mie_pkg::CMD_ORI:  alu_val = b2_a_reg | zimm;
            mie_pkg::CMD_NORI: alu_val = ~(b2_a_reg | zimm);
            mie_pkg::CMD_LUI:  alu_val = {b2_reg.imm, 16'd0};
            mie_pkg::CMD_SLTI: alu_val = {31'd0, $signed(b2_a_reg) < $signed(simm)};
            default:           alu_val = 32'd0;
        endcase
        if (b2_reg.wr_reg)
        begin
            wz = (b2_reg.rt == 5'd0);
        end
        if (b2_reg.cmd == mie_pkg::CMD_ADDI || b2_reg.is_load || b2_reg.is_store)
        begin
            nov = add_ov;
        end
        if (b2_reg.is_load || b2_reg.is_store)
        begin
            aov = (addr >= 32'(MEM_BYTES));
            if (b2_reg.cmd == mie_pkg::CMD_LW || b2_reg.cmd == mie_pkg::CMD_SW)
            begin
                mis = (addr[1:0] != 2'b00);
            end
            else if (b2_reg.cmd inside {mie_pkg::CMD_LH, mie_pkg::CMD_LHU, mie_pkg::CMD_SH})
            begin
                mis = addr[0];
            end
        end
        ok      = !wz && !nov && !aov && !mis;
        alu_rw  = b2_reg.is_alu && !wz && !nov;
        pc_next = pc_reg + 32'd4 + (taken ? {simm[29:0], 2'b00} : 32'd0);
    end

    always_comb
    begin
        word = rdata_reg;
        val3 = 32'd0;
        rw3  = 1'b0;
        mw3  = 1'b0;
        if (b3_v_reg && b3_alu_rw_reg)
        begin
            val3 = b3_val_reg;
            rw3  = 1'b1;
        end
        else if (b3_v_reg && b3_ok_reg && (b3_ld_reg || b3_st_reg))
        begin
            rw3 = b3_ld_reg;
            mw3 = b3_st_reg;
            case (b3_cmd_reg)
                mie_pkg::CMD_LW:  val3 = word;
                mie_pkg::CMD_LH:  val3 = b3_lane_reg[1] ? {{16{word[15]}}, word[15:0]}
                                                        : {{16{word[31]}}, word[31:16]};
                mie_pkg::CMD_LHU: val3 = b3_lane_reg[1] ? {16'd0, word[15:0]}
                                                        : {16'd0, word[31:16]};
                mie_pkg::CMD_LB:
                    case (b3_lane_reg)
                        2'd0:    val3 = {{24{word[31]}}, word[31:24]};
                        2'd1:    val3 = {{24{word[23]}}, word[23:16]};
                        2'd2:    val3 = {{24{word[15]}}, word[15:8]};
                        default: val3 = {{24{word[7]}}, word[7:0]};
                    endcase
                mie_pkg::CMD_LBU:
                    case (b3_lane_reg)
                        2'd0:    val3 = {24'd0, word[31:24]};
                        2'd1:    val3 = {24'd0, word[23:16]};
                        2'd2:    val3 = {24'd0, word[15:8]};
                        default: val3 = {24'd0, word[7:0]};
                    endcase
                mie_pkg::CMD_SW:  val3 = b3_b_reg;
                mie_pkg::CMD_SH:  val3 = b3_lane_reg[1] ? {word[31:16], b3_b_reg[15:0]}
                                                        : {b3_b_reg[15:0], word[15:0]};
                mie_pkg::CMD_SB:
                    case (b3_lane_reg)
                        2'd0:    val3 = {b3_b_reg[7:0], word[23:0]};
                        2'd1:    val3 = {word[31:24], b3_b_reg[7:0], word[15:0]};
                        2'd2:    val3 = {word[31:16], b3_b_reg[7:0], word[7:0]};
                        default: val3 = {word[31:8], b3_b_reg[7:0]};
                    endcase
                default:          val3 = 32'd0;
            endcase
        end
    end

    assign res_valid = b3_v_reg;
    always_comb
    begin
        res.write_zero_error = b3_wz_reg;
        res.number_overflow  = b3_nov_reg;
        res.address_overflow = b3_aov_reg;
        res.misaligned       = b3_mis_reg;
        res.halt             = b3_aov_reg | b3_mis_reg;
        res.branch_taken     = b3_tk_reg;
        res.reg_written      = rw3;
        res.mem_written      = mw3;
        res.result_value     = val3;
        res.next_pc          = b3_pc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
            b2_v_reg     <= 1'b0;
            b3_v_reg     <= 1'b0;
            pc_reg       <= 32'd0;
            for (int i = 0; i < 32; i++)
            begin
                rf_reg[i] <= 32'd0;
            end
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == AW'(MEM_WORDS - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            b2_v_reg <= issue;
            b3_v_reg <= b2_v_reg;
            if (b2_v_reg)
            begin
                pc_reg <= pc_next;
            end
            if (rw3)
            begin
                rf_reg[b3_rt_reg] <= val3;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            b2_reg   <= head;
            b2_a_reg <= fwd_a;
            b2_b_reg <= fwd_b;
        end
        if (b2_v_reg)
        begin
            b3_cmd_reg    <= b2_reg.cmd;
            b3_rt_reg     <= b2_reg.rt;
            b3_lane_reg   <= addr[1:0];
            b3_b_reg      <= b2_b_reg;
            b3_val_reg    <= alu_val;
            b3_pc_reg     <= pc_next;
            b3_idx_reg    <= idx;
            b3_ok_reg     <= ok;
            b3_ld_reg     <= b2_reg.is_load;
            b3_st_reg     <= b2_reg.is_store;
            b3_alu_rw_reg <= alu_rw;
            b3_wz_reg     <= wz;
            b3_nov_reg    <= nov;
            b3_aov_reg    <= aov;
            b3_mis_reg    <= mis;
            b3_tk_reg     <= taken;
            // store in stage 3 to the same word lands this edge
            if (mw3 && b3_idx_reg == idx)
            begin
                rdata_reg <= val3;
            end
            else
            begin
                rdata_reg <= mem[idx];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_idx_reg] <= 32'd0;
        end
        else if (mw3)
        begin
            mem[b3_idx_reg] <= val3;
        end
    end

endmodule
`default_nettype wire

// File: rtl/mie_outq.sv
`timescale 1ns / 1ps
`default_nettype none
module mie_outq (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      wr,
    input  wire mie_pkg::mie_out_t         wdata,
    input  wire logic                      pop,
    output logic                           empty,
    output mie_pkg::mie_out_t              result,
    output logic [mie_pkg::OQ_CW-1:0]      count
);

    localparam int PW = $clog2(mie_pkg::OQ_DEPTH);

    mie_pkg::mie_out_t          q_reg [mie_pkg::OQ_DEPTH];
    logic [PW-1:0]              wptr_reg, rptr_reg;
    logic [mie_pkg::OQ_CW-1:0]  cnt_reg, cnt_next;
    logic                       do_pop;

    assign empty  = (cnt_reg == '0);
    assign do_pop = pop & ~empty;
    assign result = q_reg[rptr_reg];
    assign count  = cnt_reg;
    assign cnt_next = cnt_reg + mie_pkg::OQ_CW'(wr) - mie_pkg::OQ_CW'(do_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (wr)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            q_reg[wptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

// File: dv/mie_exec_checker.sv
`timescale 1ns / 1ps
module mie_exec_checker #(
    parameter int MEM_BYTES = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              full,
    input  mie_pkg::mie_in_t  item,
    input  logic              pop,
    input  logic              empty,
    input  mie_pkg::mie_out_t result,
    output int                fail_count,
    output int                pending
);
    import mie_pkg::*;

    localparam int WORDS = (MEM_BYTES + 3) / 4;

    logic [31:0] regs [32];
    logic [31:0] dmem [WORDS];
    logic [31:0] pc;
    mie_out_t    expected_q[$];

    function automatic logic add_ovf(logic [31:0] a, logic [31:0] b);
        logic [31:0] s;
        s = a + b;
        return (a[31] == b[31]) && (s[31] != a[31]);
    endfunction

    // executes one instruction against the shadow machine state
    task automatic execute_instr(mie_in_t it);
        mie_out_t    o;
        mie_cmd_t    c;
        logic [31:0] a, b, simm, zimm, addr, word, v, npc;
        logic [1:0]  lane;
        int          sh, widx;
        logic        st;
        c    = mie_cmd_t'(it.command);
        a    = regs[it.src_reg];
        b    = regs[it.dst_reg];
        simm = {{16{it.immediate[15]}}, it.immediate};
        zimm = {16'h0, it.immediate};
        npc  = pc + 32'd4;
        o    = '0;
        v    = '0;
        if (c == CMD_BEQ || c == CMD_BNE) begin
            o.branch_taken = (c == CMD_BEQ) ? (a == b) : (a != b);
            if (o.branch_taken)
                npc = npc + (simm << 2);
        end else if (c <= CMD_SLTI) begin
            o.write_zero_error = (it.dst_reg == 0);
            case (c)
                CMD_ADDI: begin
                    o.number_overflow = add_ovf(a, simm);
                    v = a + simm;
                end
                CMD_ANDI: v = a & zimm;
                CMD_ORI:  v = a | zimm;
                CMD_NORI: v = ~(a | zimm);
                CMD_LUI:  v = {it.immediate, 16'h0};
                default:  v = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0;
            endcase
            if (!o.write_zero_error && !o.number_overflow)
                o.reg_written = 1'b1;
            else
                v = '0;
        end else begin
            addr = a + simm;
            st   = (c >= CMD_SW);
            o.write_zero_error = !st && it.dst_reg == 0;
            o.number_overflow  = add_ovf(a, simm);
            o.address_overflow = addr >= MEM_BYTES;
            if (c == CMD_LW || c == CMD_SW)
                o.misaligned = addr[1:0] != 0;
            else if (c == CMD_LH || c == CMD_LHU || c == CMD_SH)
                o.misaligned = addr[0];
            if (!o.write_zero_error && !o.number_overflow && !o.address_overflow
                && !o.misaligned) begin
                widx = addr >> 2;
                word = dmem[widx];
                lane = addr[1:0];
                case (c)
                    CMD_LW:  v = word;
                    CMD_LH:  v = lane[1] ? {{16{word[15]}}, word[15:0]}
                                         : {{16{word[31]}}, word[31:16]};
                    CMD_LHU: v = lane[1] ? {16'h0, word[15:0]} : {16'h0, word[31:16]};
                    CMD_LB, CMD_LBU:
                    begin
                        sh = (3 - lane) * 8;
                        v = (word >> sh) & 32'hFF;
                        if (c == CMD_LB && v[7])
                            v = v | 32'hFFFF_FF00;
                    end
                    CMD_SW:  v = b;
                    CMD_SH:
                    begin
                        sh = lane[1] ? 0 : 16;
                        v = (word & ~(32'hFFFF << sh)) | ((b & 32'hFFFF) << sh);
                    end
                    default:
                    begin
                        sh = (3 - lane) * 8;
                        v = (word & ~(32'hFF << sh)) | ((b & 32'hFF) << sh);
                    end
                endcase
                if (st) begin
                    dmem[widx] = v;
                    o.mem_written = 1'b1;
                end else begin
                    o.reg_written = 1'b1;
                end
            end
        end
        if (o.reg_written)
            regs[it.dst_reg] = v;
        pc = npc;
        o.halt = o.address_overflow | o.misaligned;
        o.result_value = v;
        o.next_pc = npc;
        expected_q.push_back(o);
    endtask

    task automatic compare_result(mie_out_t got);
        mie_out_t e;
        if (expected_q.size() == 0) begin
            $error("result with nothing expected: %h", got);
            fail_count++;
            return;
        end
        e = expected_q.pop_front();
        if (got.write_zero_error !== e.write_zero_error) begin
            $error("write_zero_error exp %b got %b", e.write_zero_error, got.write_zero_error);
            fail_count++;
        end
        if (got.number_overflow !== e.number_overflow) begin
            $error("number_overflow exp %b got %b", e.number_overflow, got.number_overflow);
            fail_count++;
        end
        if (got.address_overflow !== e.address_overflow) begin
            $error("address_overflow exp %b got %b", e.address_overflow, got.address_overflow);
            fail_count++;
        end
        if (got.misaligned !== e.misaligned) begin
            $error("misaligned exp %b got %b", e.misaligned, got.misaligned);
            fail_count++;
        end
        if (got.halt !== e.halt) begin
            $error("halt exp %b got %b", e.halt, got.halt);
            fail_count++;
        end
        if (got.branch_taken !== e.branch_taken) begin
            $error("branch_taken exp %b got %b", e.branch_taken, got.branch_taken);
            fail_count++;
        end
        if (got.reg_written !== e.reg_written) begin
            $error("reg_written exp %b got %b", e.reg_written, got.reg_written);
            fail_count++;
        end
        if (got.mem_written !== e.mem_written) begin
            $error("mem_written exp %b got %b", e.mem_written, got.mem_written);
            fail_count++;
        end
        if (got.result_value !== e.result_value) begin
            $error("result_value exp %h got %h", e.result_value, got.result_value);
            fail_count++;
        end
        if (got.next_pc !== e.next_pc) begin
            $error("next_pc exp %h got %h", e.next_pc, got.next_pc);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < 32; i++)
                regs[i] = '0;
            for (int i = 0; i < WORDS; i++)
                dmem[i] = '0;
            pc = '0;
            expected_q.delete();
            fail_count = 0;
            pending = 0;
        end else begin
            if (pop && !empty)
                compare_result(result);
            if (push && !full)
                execute_instr(item);
            pending = expected_q.size();
        end
    end
endmodule

// File: dv/tb_mips_itype_execute_top.sv
`timescale 1ns / 1ps
module tb_mips_itype_execute_top;

    localparam int MEM_BYTES   = 1024;
    localparam int RAND_ITEMS  = 1450;
    localparam int CYCLE_LIMIT = 200000;

    logic              clk;
    logic              rst_n;
    logic              push;
    mie_pkg::mie_in_t  item;
    logic              full;
    logic              pop;
    logic              empty;
    mie_pkg::mie_out_t result;
    int                fail_count;
    int                pending;
    int                cycles;
    logic              hold_pop;
    logic              hold_req;
    logic              stim_done;

    mips_itype_execute_top #(.MEM_BYTES(MEM_BYTES)) u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .item(item), .full(full),
        .pop(pop), .empty(empty), .result(result)
    );

    mie_exec_checker #(.MEM_BYTES(MEM_BYTES)) u_checker (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .item(item),
        .pop(pop), .empty(empty), .result(result),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // one instruction transaction, held until accepted
    task automatic send_instr(mie_pkg::mie_cmd_t c, logic [4:0] rs, logic [4:0] rt,
                              logic [15:0] imm);
        push <= 1'b1;
        item <= '{command: c, src_reg: rs, dst_reg: rt, immediate: imm};
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic go_idle();
        push <= 1'b0;
    endtask

    // mostly in-range addresses: most loads and stores use r0 as base with a small offset
    task automatic send_random();
        mie_pkg::mie_cmd_t c;
        logic [4:0]        rs, rt;
        logic [15:0]       imm;
        int                k;
        c   = mie_pkg::mie_cmd_t'($urandom_range(0, 15));
        rs  = 5'($urandom_range(0, 31));
        rt  = 5'($urandom_range(0, 31));
        imm = 16'($urandom);
        k   = $urandom_range(0, 9);
        if (c >= mie_pkg::CMD_LW && k < 7)
        begin
            rs  = 5'($urandom_range(0, 3));
            imm = 16'($urandom_range(0, MEM_BYTES - 1));
            if ((c == mie_pkg::CMD_LW || c == mie_pkg::CMD_SW) && k < 5)
                imm[1:0] = 2'b00;
            else if ((c == mie_pkg::CMD_LH || c == mie_pkg::CMD_LHU
                      || c == mie_pkg::CMD_SH) && k < 5)
                imm[0] = 1'b0;
        end
        if (c >= mie_pkg::CMD_LW && rs <= 3 && k < 7 && rs != 0)
            rs = 0;
        if (c < mie_pkg::CMD_LW && k == 0)
            rt = rs;
        send_instr(c, rs, rt, imm);
    endtask

    task automatic wait_drained();
        go_idle();
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // long receiver hold-off, timed here while the sender keeps offering
    initial
    begin
        hold_pop = 1'b0;
        wait (hold_req);
        hold_pop = 1'b1;
        repeat (100) @(negedge clk);
        hold_pop = 1'b0;
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_pop)
            pop <= 1'b0;
        else if (cycles % 600 < 150)
            pop <= 1'b1;
        else
            pop <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        if (rst_n)
            cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int n;
        int burst;
        rst_n = 1'b0;
        push = 1'b0;
        item = '0;
        pop = 1'b0;
        hold_req = 1'b0;
        stim_done = 1'b0;
        cycles = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: build state, then cover ops and corner flags
        send_instr(mie_pkg::CMD_LUI,  5'd0,  5'd1,  16'h1234);
        send_instr(mie_pkg::CMD_ORI,  5'd0,  5'd2,  16'hFFFF);
        send_instr(mie_pkg::CMD_ADDI, 5'd0,  5'd3,  16'h8000);
        send_instr(mie_pkg::CMD_LUI,  5'd0,  5'd4,  16'h7FFF);
        send_instr(mie_pkg::CMD_ORI,  5'd4,  5'd4,  16'hFFFF);
        send_instr(mie_pkg::CMD_ADDI, 5'd4,  5'd5,  16'h0001);
        send_instr(mie_pkg::CMD_NORI, 5'd1,  5'd6,  16'h00F0);
        send_instr(mie_pkg::CMD_ANDI, 5'd6,  5'd7,  16'hFFFF);
        send_instr(mie_pkg::CMD_SLTI, 5'd3,  5'd8,  16'h7FFF);
        send_instr(mie_pkg::CMD_SLTI, 5'd2,  5'd8,  16'h8000);
        send_instr(mie_pkg::CMD_ADDI, 5'd1,  5'd0,  16'h0005);
        send_instr(mie_pkg::CMD_SW,   5'd0,  5'd6,  16'h03FC);
        send_instr(mie_pkg::CMD_SB,   5'd0,  5'd2,  16'h03FD);
        send_instr(mie_pkg::CMD_SH,   5'd0,  5'd1,  16'h03FE);
        send_instr(mie_pkg::CMD_LW,   5'd0,  5'd9,  16'h03FC);
        send_instr(mie_pkg::CMD_LH,   5'd0,  5'd9,  16'h03FC);
        send_instr(mie_pkg::CMD_LHU,  5'd0,  5'd9,  16'h03FE);
        send_instr(mie_pkg::CMD_LB,   5'd0,  5'd9,  16'h03FD);
        send_instr(mie_pkg::CMD_LBU,  5'd0,  5'd9,  16'h03FF);
        send_instr(mie_pkg::CMD_LW,   5'd0,  5'd9,  16'h0402);
        send_instr(mie_pkg::CMD_LH,   5'd0,  5'd0,  16'hFFFF);
        send_instr(mie_pkg::CMD_SW,   5'd4,  5'd1,  16'h7FFF);
        send_instr(mie_pkg::CMD_BEQ,  5'd0,  5'd10, 16'h8000);
        send_instr(mie_pkg::CMD_BNE,  5'd1,  5'd2,  16'h7FFF);
        send_instr(mie_pkg::CMD_BNE,  5'd0,  5'd0,  16'h0004);
        // clear base registers 1 and 2 and set register 3 to 0x100 so random loads and stores mostly land in memory
        send_instr(mie_pkg::CMD_ANDI, 5'd0,  5'd1,  16'h0000);
        send_instr(mie_pkg::CMD_ANDI, 5'd0,  5'd2,  16'h0000);
        send_instr(mie_pkg::CMD_ORI,  5'd0,  5'd3,  16'h0100);
        wait_drained();

        n = 0;
        while (n < RAND_ITEMS)
        begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst && n < RAND_ITEMS; i++)
            begin
                send_random();
                n++;
            end
            go_idle();
            if (n >= 400 && n < 440)
            begin
                // fill the block while the receiver holds off
                hold_req = 1'b1;
                for (int i = 0; i < 60; i++)
                begin
                    send_random();
                    n++;
                end
                go_idle();
                wait (!hold_pop);
            end
            else if (n >= 900 && n < 940)
            begin
                wait_drained();
            end
            else
            begin
                repeat ($urandom_range(0, 6)) @(negedge clk);
            end
        end
        go_idle();
        stim_done = 1'b1;
        wait_drained();
        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
